// ===== rtl/emd_pkg.sv =====
package emd_pkg;

   localparam int RAW_W = 24;
   localparam int VAL_W = 26;
   localparam int SUM_W = 30;
   localparam int UV_W = 22;
   localparam int ACT_W = 2;
   localparam int NUM_LANES = 3;
   localparam int WINDOW = 5;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int DECIM_DEFAULT = 4;
   localparam int UV_DIVISOR = 28;
   localparam int MIDSCALE = 6400000;
   localparam int ACTIVE_RESET = 3;
   localparam int FIFO_DEPTH = 16;

   typedef logic [RAW_W-1:0] raw_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [UV_W-1:0] uv_type;
   typedef logic [ACT_W-1:0] act_type;
   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic     valid;
      slot_type slot;
      logic     last;
   } lane_ctl_type;

endpackage

// ===== rtl/emd_if.sv =====
interface emd_req_if;
   import emd_pkg::*;
   logic    valid;
   logic    ready;
   raw_type raw_ch1;
   raw_type raw_ch2;
   raw_type raw_ch3;
   modport source (output valid, output raw_ch1, output raw_ch2, output raw_ch3,
                   input ready);
   modport sink (input valid, input raw_ch1, input raw_ch2, input raw_ch3,
                 output ready);
endinterface

interface emd_rsp_if;
   import emd_pkg::*;
   logic   valid;
   logic   ready;
   uv_type uv_ch1;
   uv_type uv_ch2;
   uv_type uv_ch3;
   modport source (output valid, output uv_ch1, output uv_ch2, output uv_ch3,
                   input ready);
   modport sink (input valid, input uv_ch1, input uv_ch2, input uv_ch3,
                 output ready);
endinterface

interface emd_csr_if;
   import emd_pkg::*;
   logic    valid;
   logic    ready;
   act_type active_channels;
   modport source (output valid, output active_channels, input ready);
   modport sink (input valid, input active_channels, output ready);
endinterface

// ===== rtl/ecg_median_decimator_unit.sv =====
// Three-channel ECG front end: median-of-five filter followed by a boxcar
// decimator by DECIM.
// The req_if channel carries one frame of three unsigned 24-bit ADC codes per
// item. Every active channel is offset to midscale, scaled, filtered through
// its own five-entry window and summed; every DECIM-th item produces one
// rsp_if item holding the three averages in microvolts. Inactive channels
// report zero.
// Throughput is one item per cycle while req_if.ready is high. The result of
// the DECIM-th item passes through windowing, the median network and
// accumulation, then reciprocal division, and then enters the output queue
// before it appears on rsp_if.
// Finished results wait in a 16-deep output queue, so the block keeps taking
// items while rsp_if is stalled until 16 results are owed; then req_if.ready
// drops until the receiver takes one.
// The csr_if channel writes active_channels; a write also clears the windows,
// the window pointer, the sums and the frame count, and is meant to be done
// while the block is idle. Reset sets active_channels to three, clears the
// same state and empties the queue.
module ecg_median_decimator_unit #(
   parameter int DECIM = emd_pkg::DECIM_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   emd_req_if.sink         req_if,
   emd_rsp_if.source       rsp_if,
   emd_csr_if.sink         csr_if
);
   import emd_pkg::*;

   localparam int CNT_W = (DECIM > 1) ? $clog2(DECIM) : 1;

   act_type          active_ff;
   slot_type         ptr_ff, ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             cfg_write;
   logic             room;
   lane_ctl_type     ctl;
   raw_type          raw [NUM_LANES];
   logic [NUM_LANES-1:0] dump_valid;
   sum_type          dump_sum [NUM_LANES];
   logic [NUM_LANES-1:0] div_valid;
   uv_type           div_uv [NUM_LANES];
   uv_type           rsp_uv [NUM_LANES];

   assign accept = req_if.valid && req_if.ready;
   assign cfg_write = csr_if.valid && csr_if.ready;
   assign req_if.ready = room;
   assign csr_if.ready = 1'b1;

   assign ctl.valid = accept;
   assign ctl.slot = ptr_ff;
   assign ctl.last = (count_ff == CNT_W'(DECIM - 1));

   assign ptr_in = (ptr_ff == SLOT_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
   assign count_in = ctl.last ? '0 : count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACT_W'(ACTIVE_RESET);
         ptr_ff <= '0;
         count_ff <= '0;
      end else if (cfg_write) begin
         active_ff <= csr_if.active_channels;
         ptr_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         ptr_ff <= ptr_in;
         count_ff <= count_in;
      end
   end

   assign raw[0] = req_if.raw_ch1;
   assign raw[1] = req_if.raw_ch2;
   assign raw[2] = req_if.raw_ch3;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      emd_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .clear      (cfg_write),
         .active     (active_ff > ACT_W'(g)),
         .ctl_in     (ctl),
         .raw        (raw[g]),
         .dump_valid (dump_valid[g]),
         .dump_sum   (dump_sum[g])
      );

      emd_div #(
         .DECIM (DECIM)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dump_valid[g]),
         .in_sum    (dump_sum[g]),
         .out_valid (div_valid[g]),
         .out_uv    (div_uv[g])
      );
   end

   emd_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (&div_valid),
      .uv_in     (div_uv),
      .take_last (accept && ctl.last),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_uv    (rsp_uv),
      .room      (room)
   );

   assign rsp_if.uv_ch1 = rsp_uv[0];
   assign rsp_if.uv_ch2 = rsp_uv[1];
   assign rsp_if.uv_ch3 = rsp_uv[2];

endmodule

// ===== rtl/emd_lane.sv =====
module emd_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  active,
   input  emd_pkg::lane_ctl_type ctl_in,
   input  emd_pkg::raw_type      raw,
   output logic                  dump_valid,
   output emd_pkg::sum_type      dump_sum
);
   import emd_pkg::*;

   localparam int DEPTH = 5;

   val_type      diff;
   val_type      scaled_in;
   val_type      scaled_ff;
   lane_ctl_type ctl_ff [DEPTH];
   val_type      win_ff [WINDOW];
   val_type      win_in [WINDOW];
   val_type      lo_a_ff, hi_a_ff, lo_b_ff, hi_b_ff, e1_ff;
   val_type      x2_ff, y2_ff, z2_ff, e2_ff;
   val_type      x3_ff, y3_ff, p3_ff, q3_ff;
   val_type      mx4_ff, mn4_ff;
   val_type      med;
   sum_type      addend;
   sum_type      total;
   sum_type      sum_ff;
   sum_type      sum_in;
   sum_type      dump_sum_ff;
   logic         dump_valid_ff;

   assign diff = $signed({{(VAL_W-RAW_W){1'b0}}, raw}) - VAL_W'(MIDSCALE);
   assign scaled_in = (diff <<< 1) + diff;

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         win_in[i] = (ctl_ff[0].slot == SLOT_W'(i)) ? scaled_ff : win_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ctl_ff[i].valid <= 1'b0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < DEPTH; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
      end else if (ctl_ff[0].valid && active) begin
         win_ff <= win_in;
      end
   end

   // Median of five: sort two pairs, drop the lower of the two pair minimums,
   // then take the second smallest of the remaining four.
   always_ff @(posedge clock) begin
      if (ctl_in.valid) begin
         scaled_ff <= scaled_in;
      end
      lo_a_ff <= (win_in[0] < win_in[1]) ? win_in[0] : win_in[1];
      hi_a_ff <= (win_in[0] < win_in[1]) ? win_in[1] : win_in[0];
      lo_b_ff <= (win_in[2] < win_in[3]) ? win_in[2] : win_in[3];
      hi_b_ff <= (win_in[2] < win_in[3]) ? win_in[3] : win_in[2];
      e1_ff <= win_in[4];
      if (lo_a_ff < lo_b_ff) begin
         x2_ff <= lo_b_ff;
         y2_ff <= hi_b_ff;
         z2_ff <= hi_a_ff;
      end else begin
         x2_ff <= lo_a_ff;
         y2_ff <= hi_a_ff;
         z2_ff <= hi_b_ff;
      end
      e2_ff <= e1_ff;
      x3_ff <= x2_ff;
      y3_ff <= y2_ff;
      p3_ff <= (z2_ff < e2_ff) ? z2_ff : e2_ff;
      q3_ff <= (z2_ff < e2_ff) ? e2_ff : z2_ff;
      mx4_ff <= (x3_ff < p3_ff) ? p3_ff : x3_ff;
      mn4_ff <= (y3_ff < q3_ff) ? y3_ff : q3_ff;
   end

   assign med = (mx4_ff < mn4_ff) ? mx4_ff : mn4_ff;
   assign addend = active ? sum_type'(med) : '0;
   assign total = sum_ff + addend;
   assign sum_in = ctl_ff[DEPTH-1].last ? '0 : total;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         sum_ff <= '0;
         dump_valid_ff <= 1'b0;
      end else begin
         if (ctl_ff[DEPTH-1].valid) begin
            sum_ff <= sum_in;
         end
         dump_valid_ff <= ctl_ff[DEPTH-1].valid && ctl_ff[DEPTH-1].last;
      end
   end

   always_ff @(posedge clock) begin
      dump_sum_ff <= total;
   end

   assign dump_valid = dump_valid_ff;
   assign dump_sum = dump_sum_ff;

endmodule

// ===== rtl/emd_div.sv =====
module emd_div #(
   parameter int DECIM = emd_pkg::DECIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  emd_pkg::sum_type in_sum,
   output logic             out_valid,
   output emd_pkg::uv_type  out_uv
);
   import emd_pkg::*;

   localparam int MAG_W = SUM_W - 1;
   localparam int DIVISOR = UV_DIVISOR * DECIM;
   localparam int DIV_W = $clog2(DIVISOR + 1);
   localparam int RECIP = (1 << MAG_W) / DIVISOR;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W = MAG_W + RECIP_W;
   localparam int BACK_W = RECIP_W + DIV_W;
   localparam int STAGES = 5;

   logic [STAGES-1:0]  valid_ff;
   logic [MAG_W-1:0]   mag_in;
   logic [MAG_W-1:0]   mag1_ff, mag2_ff, mag3_ff;
   logic               neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [PROD_W-1:0]  prod2_ff;
   logic [RECIP_W-1:0] q0_in;
   logic [RECIP_W-1:0] q0_3_ff;
   logic [BACK_W-1:0]  back3_ff;
   logic [MAG_W-1:0]   rem;
   logic [RECIP_W-1:0] q4_ff;
   uv_type             uv5_ff;

   assign mag_in = in_sum[SUM_W-1] ? MAG_W'(-in_sum) : MAG_W'(in_sum);
   assign q0_in = prod2_ff[MAG_W +: RECIP_W];
   assign rem = mag3_ff - MAG_W'(back3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   // The reciprocal estimate is low by at most one; the remainder fixes it.
   always_ff @(posedge clock) begin
      mag1_ff <= mag_in;
      neg1_ff <= in_sum[SUM_W-1];
      prod2_ff <= PROD_W'(mag1_ff) * PROD_W'(RECIP);
      mag2_ff <= mag1_ff;
      neg2_ff <= neg1_ff;
      q0_3_ff <= q0_in;
      back3_ff <= BACK_W'(q0_in) * BACK_W'(DIVISOR);
      mag3_ff <= mag2_ff;
      neg3_ff <= neg2_ff;
      q4_ff <= q0_3_ff + RECIP_W'(rem >= MAG_W'(DIVISOR));
      neg4_ff <= neg3_ff;
      uv5_ff <= neg4_ff ? -UV_W'(q4_ff) : UV_W'(q4_ff);
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_uv = uv5_ff;

endmodule

// ===== rtl/emd_merge.sv =====
module emd_merge (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  emd_pkg::uv_type uv_in [emd_pkg::NUM_LANES],
   input  logic            take_last,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output emd_pkg::uv_type rsp_uv [emd_pkg::NUM_LANES],
   output logic            room
);
   import emd_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   uv_type           fifo_ff [FIFO_DEPTH][NUM_LANES];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             pop;

   assign pop = rsp_valid && rsp_ready;
   assign count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   assign pending_in = pending_ff + CNT_W'(take_last) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         pending_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= uv_in;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_uv = fifo_ff[rd_ptr_ff];
   assign room = (pending_ff < CNT_W'(FIFO_DEPTH));

endmodule

// ===== rtl/emd_checker.sv =====
module emd_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            csr_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input emd_pkg::uv_type rsp_uv_ch1,
   input emd_pkg::uv_type rsp_uv_ch2,
   input emd_pkg::uv_type rsp_uv_ch3
);
   import emd_pkg::*;

   // Reset empties the result queue and leaves nothing owed.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready && csr_ready)
      else $error("block not ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_uv_ch1) && $stable(rsp_uv_ch2) && $stable(rsp_uv_ch3))
      else $error("stalled result changed");

endmodule

bind ecg_median_decimator_unit emd_checker u_emd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .csr_ready  (csr_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_uv_ch1 (rsp_if.uv_ch1),
   .rsp_uv_ch2 (rsp_if.uv_ch2),
   .rsp_uv_ch3 (rsp_if.uv_ch3)
);
